FILE: rtl/tsvr_pkg.sv
`timescale 1ns / 1ps

package tsvr_pkg;

    // Field and counter widths
    localparam int STEP_BITS     = 24;
    localparam int VEL_FRAC_BITS = 8;
    localparam int VEL_INT_BITS  = 12;
    localparam int VEL_BITS      = VEL_INT_BITS + VEL_FRAC_BITS;
    localparam int PER_FRAC_BITS = 12;
    localparam int PER_BITS      = 22;
    localparam int MOVE_BITS     = 24;
    localparam int MIN_BITS      = 28;
    localparam int SPEED_BITS    = 12;
    localparam int DUR_BITS      = 8;
    localparam int PHASE_BITS    = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // Period numerator 1000 scaled for a Q10.12 result over a fixed-point velocity
    localparam longint unsigned PER_NUM = 64'd1000 << (PER_FRAC_BITS + VEL_FRAC_BITS);
    // Velocities at or below this give a period beyond the field
    localparam longint unsigned PER_SAT = PER_NUM >> PER_BITS;
    localparam logic [PER_BITS-1:0] PER_NUM_LOW = PER_BITS'(PER_NUM);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VEL   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VEL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_DUR = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECEL_DUR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_LEN  = 3'd4;

    // Configuration reset values
    localparam logic [SPEED_BITS-1:0] RST_MIN_VEL   = 12'd1;
    localparam logic [SPEED_BITS-1:0] RST_MAX_VEL   = 12'd10;
    localparam logic [DUR_BITS-1:0]   RST_ACCEL_DUR = 8'd3;
    localparam logic [DUR_BITS-1:0]   RST_DECEL_DUR = 8'd3;
    localparam logic [MOVE_BITS-1:0]  RST_MOVE_LEN  = 24'd40;

    // Profile phase codes
    localparam logic [PHASE_BITS-1:0] PH_ACCEL  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_CRUISE = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_BRAKE  = 2'd2;

endpackage

FILE: rtl/tsvr_if.sv
`timescale 1ns / 1ps

// Step request channel
interface tsvr_in_if;
    import tsvr_pkg::*;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// Step result channel
interface tsvr_out_if;
    import tsvr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [MOVE_BITS-1:0]  step_index;
    logic [VEL_BITS-1:0]   velocity;
    logic [PER_BITS-1:0]   period;
    logic [PHASE_BITS-1:0] phase;
    logic                  last;
    logic                  too_short;
    logic [MIN_BITS-1:0]   min_steps;
    modport source (output valid, output step_index, output velocity, output period,
                    output phase, output last, output too_short, output min_steps,
                    input ready);
    modport sink (input valid, input step_index, input velocity, input period,
                  input phase, input last, input too_short, input min_steps,
                  output ready);
endinterface

// Configuration write channel
interface tsvr_cfg_if;
    import tsvr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/trapezoid_step_velocity_ramp.sv
// Requests use the shared shift-subtract unit (12 + 12 rate division steps, 20 square
// root steps on a ramp, 22 period division steps) and the multiplier. A new request is
// taken only once the previous one has finished; a result may wait in the output register
// while the next request is taken. Synchronous active-low reset restores the register
// defaults and clears the step counter.
`timescale 1ns / 1ps

module trapezoid_step_velocity_ramp (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsvr_cfg_if.sink   i_cfg,
    tsvr_in_if.sink    i_in,
    tsvr_out_if.source o_out
);
    import tsvr_pkg::*;

    localparam int X_BITS     = 2 * VEL_BITS;
    localparam int Q_BITS     = (VEL_BITS > PER_BITS) ? VEL_BITS : PER_BITS;
    localparam int REM_BITS   = VEL_BITS + 3;
    localparam int CNT_BITS   = $clog2(Q_BITS);
    localparam int CMP_BITS   = ((STEP_BITS > MOVE_BITS) ? STEP_BITS : MOVE_BITS) + 1;
    localparam int MA_BITS    = MOVE_BITS + 1;
    localparam int MB_BITS    = SPEED_BITS + 2;
    localparam int P_BITS     = MA_BITS + MB_BITS;
    localparam int R_BITS     = MOVE_BITS + 1;
    localparam int RAD_BITS   = P_BITS + 2;
    localparam int RSAT_BITS  = 2 * VEL_INT_BITS;
    localparam int MSTEP_BITS = 4;

    // Multiplier sequence steps
    localparam logic [MSTEP_BITS-1:0] MS_ACC_TA   = 4'd0;
    localparam logic [MSTEP_BITS-1:0] MS_ACC_TA2  = 4'd1;
    localparam logic [MSTEP_BITS-1:0] MS_VMIN_TA  = 4'd2;
    localparam logic [MSTEP_BITS-1:0] MS_DEC_TD   = 4'd3;
    localparam logic [MSTEP_BITS-1:0] MS_DEC_TD2  = 4'd4;
    localparam logic [MSTEP_BITS-1:0] MS_VMIN_TD  = 4'd5;
    localparam logic [MSTEP_BITS-1:0] MS_VMIN_SQ  = 4'd6;
    localparam logic [MSTEP_BITS-1:0] MS_VMAX_SQ  = 4'd7;
    localparam logic [MSTEP_BITS-1:0] MS_BOUNDS   = 4'd8;
    localparam logic [MSTEP_BITS-1:0] MS_PHASE    = 4'd9;
    localparam logic [MSTEP_BITS-1:0] MS_VEL_MUL  = 4'd10;
    localparam logic [MSTEP_BITS-1:0] MS_RADICAND = 4'd11;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIVA   = 8'b0000_0010,
        ST_DIVD   = 8'b0000_0100,
        ST_MUL    = 8'b0000_1000,
        ST_SQRT   = 8'b0001_0000,
        ST_PSTART = 8'b0010_0000,
        ST_PDIV   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    // Control registers
    t_state                  r_state;
    logic [MSTEP_BITS-1:0]   r_mstep;
    logic                    r_ovalid;
    logic [STEP_BITS-1:0]    r_step_cnt;
    logic [SPEED_BITS-1:0]   r_vmin;
    logic [SPEED_BITS-1:0]   r_vmax;
    logic [DUR_BITS-1:0]     r_ta;
    logic [DUR_BITS-1:0]     r_td;
    logic [MOVE_BITS-1:0]    r_total;

    // Shared shift-subtract unit
    logic [X_BITS-1:0]       r_x;
    logic [REM_BITS-1:0]     r_rem;
    logic [Q_BITS-1:0]       r_q;
    logic [VEL_BITS-1:0]     r_dvs;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [X_BITS-1:0]       n_x;
    logic [REM_BITS-1:0]     rem_sh;
    logic [REM_BITS-1:0]     trial;
    logic                    take;
    logic [REM_BITS-1:0]     n_rem;
    logic [Q_BITS-1:0]       n_q;
    logic                    unit_last;

    // Shared multiplier
    logic signed [MA_BITS-1:0] mul_a;
    logic signed [MB_BITS-1:0] mul_b;
    logic signed [P_BITS-1:0]  n_prod;
    logic signed [P_BITS-1:0]  r_prod;

    // Profile datapath
    logic signed [SPEED_BITS:0]  diff;
    logic                        diff_neg;
    logic [SPEED_BITS-1:0]       diff_mag;
    logic signed [SPEED_BITS:0]  q_s;
    logic                        rate_zero;
    logic signed [SPEED_BITS:0]  n_rate;
    logic signed [SPEED_BITS:0]  r_acc;
    logic signed [SPEED_BITS:0]  r_dec;
    logic signed [R_BITS-1:0]    r_ra;
    logic signed [R_BITS-1:0]    r_rd;
    logic [R_BITS-1:0]           ra_p1;
    logic [R_BITS-1:0]           rd_p1;
    logic [R_BITS-2:0]           r_ceil_a;
    logic [R_BITS-2:0]           r_ceil_d;
    logic [R_BITS-1:0]           ceil_sum;
    logic [RSAT_BITS-1:0]        r_vv;
    logic [RSAT_BITS-1:0]        r_vx;
    logic                        r_short;
    logic [MIN_BITS-1:0]         r_min;
    logic [MOVE_BITS-1:0]        r_step;
    logic [R_BITS-1:0]           r_brk;
    logic [PHASE_BITS-1:0]       r_phase;
    logic signed [MOVE_BITS+2:0] k_full;
    logic signed [MA_BITS-1:0]   r_k;
    logic signed [RAD_BITS-1:0]  rad;
    logic                        rad_pos;
    logic                        rad_big;
    logic [VEL_BITS-1:0]         r_vq;
    logic [PER_BITS-1:0]         r_per;
    logic                        step_last;
    logic                        per_sat;

    // Output register
    logic [MOVE_BITS-1:0]  r_o_step;
    logic [VEL_BITS-1:0]   r_o_vel;
    logic [PER_BITS-1:0]   r_o_per;
    logic [PHASE_BITS-1:0] r_o_phase;
    logic                  r_o_last;
    logic                  r_o_short;
    logic [MIN_BITS-1:0]   r_o_min;

    logic in_xfer;
    logic out_free;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && (r_state == ST_IDLE);
    assign out_free    = !r_ovalid || o_out.ready;

    assign o_out.valid      = r_ovalid;
    assign o_out.step_index = r_o_step;
    assign o_out.velocity   = r_o_vel;
    assign o_out.period     = r_o_per;
    assign o_out.phase      = r_o_phase;
    assign o_out.last       = r_o_last;
    assign o_out.too_short  = r_o_short;
    assign o_out.min_steps  = r_o_min;

    // Velocity span and its magnitude for the rate divisions
    assign diff     = $signed({1'b0, r_vmax}) - $signed({1'b0, r_vmin});
    assign diff_neg = diff[SPEED_BITS];
    assign diff_mag = diff_neg ? SPEED_BITS'(-diff) : SPEED_BITS'(diff);

    // Shift-subtract step: two radicand bits for the root, one dividend bit otherwise
    always_comb begin
        if (r_state == ST_SQRT) begin
            rem_sh = {r_rem[REM_BITS-3:0], r_x[X_BITS-1 -: 2]};
            trial  = {1'b0, r_q[VEL_BITS-1:0], 2'b01};
            n_x    = r_x << 2;
        end else begin
            rem_sh = {r_rem[REM_BITS-2:0], r_x[X_BITS-1]};
            trial  = REM_BITS'(r_dvs);
            n_x    = r_x << 1;
        end
        take  = (rem_sh >= trial);
        n_rem = take ? (rem_sh - trial) : rem_sh;
        n_q   = {r_q[Q_BITS-2:0], take};
    end

    assign unit_last = (r_cnt == '0);

    // Signed rate from the finished quotient; a zero duration gives zero
    assign q_s       = $signed({1'b0, n_q[SPEED_BITS-1:0]});
    assign rate_zero = (r_state == ST_DIVA) ? (r_ta == '0) : (r_td == '0);
    assign n_rate    = rate_zero ? '0 : (diff_neg ? -q_s : q_s);

    // Multiplier operand selection per sequence step
    always_comb begin
        case (r_mstep)
            MS_ACC_TA: begin
                mul_a = $signed(MA_BITS'(r_ta));
                mul_b = MB_BITS'(r_acc);
            end
            MS_ACC_TA2: begin
                mul_a = $signed(MA_BITS'(r_ta));
                mul_b = r_prod[MB_BITS-1:0];
            end
            MS_VMIN_TA: begin
                mul_a = $signed(MA_BITS'(r_ta));
                mul_b = $signed(MB_BITS'(r_vmin));
            end
            MS_DEC_TD: begin
                mul_a = $signed(MA_BITS'(r_td));
                mul_b = MB_BITS'(r_dec);
            end
            MS_DEC_TD2: begin
                mul_a = $signed(MA_BITS'(r_td));
                mul_b = r_prod[MB_BITS-1:0];
            end
            MS_VMIN_TD: begin
                mul_a = $signed(MA_BITS'(r_td));
                mul_b = $signed(MB_BITS'(r_vmin));
            end
            MS_VMIN_SQ: begin
                mul_a = $signed(MA_BITS'(r_vmin));
                mul_b = $signed(MB_BITS'(r_vmin));
            end
            MS_VMAX_SQ: begin
                mul_a = $signed(MA_BITS'(r_vmax));
                mul_b = $signed(MB_BITS'(r_vmax));
            end
            MS_VEL_MUL: begin
                if (r_phase == PH_ACCEL) begin
                    mul_a = $signed(MA_BITS'(r_step));
                    mul_b = MB_BITS'(r_acc);
                end else begin
                    mul_a = r_k;
                    mul_b = MB_BITS'(r_dec);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Ramp bounds and the braking offset
    assign ra_p1    = r_ra + R_BITS'(1);
    assign rd_p1    = r_rd + R_BITS'(1);
    assign ceil_sum = {1'b0, r_ceil_a} + {1'b0, r_ceil_d};
    assign k_full   = $signed({2'b00, r_step, 1'b0}) - $signed({2'b00, r_total, 1'b0})
                    + $signed((MOVE_BITS+3)'(2)) + (MOVE_BITS+3)'(r_rd);

    // Squared velocity from the product
    always_comb begin
        if (r_phase == PH_ACCEL) begin
            rad = $signed({r_prod[P_BITS-1], r_prod, 1'b0}) + $signed(RAD_BITS'(r_vv));
        end else begin
            rad = $signed(RAD_BITS'(r_vx)) - $signed({{2{r_prod[P_BITS-1]}}, r_prod});
        end
    end

    assign rad_pos   = !rad[RAD_BITS-1] && (rad != '0);
    assign rad_big   = !rad[RAD_BITS-1] && (|rad[RAD_BITS-2:RSAT_BITS]);
    assign per_sat   = (r_vq <= VEL_BITS'(PER_SAT));
    assign step_last = (({1'b0, r_step} + (MOVE_BITS+1)'(1)) == {1'b0, r_total});

    // Sequencer, configuration, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mstep    <= '0;
            r_ovalid   <= 1'b0;
            r_step_cnt <= '0;
            r_vmin     <= RST_MIN_VEL;
            r_vmax     <= RST_MAX_VEL;
            r_ta       <= RST_ACCEL_DUR;
            r_td       <= RST_DECEL_DUR;
            r_total    <= RST_MOVE_LEN;
        end else begin
            // Take register writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_MIN_VEL:   r_vmin  <= i_cfg.data[SPEED_BITS-1:0];
                    CFG_MAX_VEL:   r_vmax  <= i_cfg.data[SPEED_BITS-1:0];
                    CFG_ACCEL_DUR: r_ta    <= i_cfg.data[DUR_BITS-1:0];
                    CFG_DECEL_DUR: r_td    <= i_cfg.data[DUR_BITS-1:0];
                    CFG_MOVE_LEN:  r_total <= i_cfg.data[MOVE_BITS-1:0];
                    default: ;
                endcase
            end

            // Raise valid when a result is loaded, drop it once its transfer completes
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.restart) begin
                            r_step_cnt <= '0;
                        end
                        r_state <= ST_DIVA;
                    end
                end
                ST_DIVA: begin
                    if (unit_last) begin
                        r_state <= ST_DIVD;
                    end
                end
                ST_DIVD: begin
                    if (unit_last) begin
                        r_mstep <= MS_ACC_TA;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_mstep <= r_mstep + MSTEP_BITS'(1);
                    if (r_mstep == MS_VEL_MUL) begin
                        if (r_short) begin
                            r_state <= ST_DONE;
                        end else if (r_phase == PH_CRUISE) begin
                            r_state <= ST_PSTART;
                        end
                    end else if (r_mstep == MS_RADICAND) begin
                        r_state <= (rad_pos && !rad_big) ? ST_SQRT : ST_PSTART;
                    end
                end
                ST_SQRT: begin
                    if (unit_last) begin
                        r_state <= ST_PSTART;
                    end
                end
                ST_PSTART: begin
                    r_state <= per_sat ? ST_DONE : ST_PDIV;
                end
                ST_PDIV: begin
                    if (unit_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (!r_short) begin
                            r_step_cnt <= step_last ? '0
                                        : STEP_BITS'(r_step) + STEP_BITS'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                // Load the acceleration rate division
                r_x   <= {diff_mag, {(X_BITS-SPEED_BITS){1'b0}}};
                r_rem <= '0;
                r_q   <= '0;
                r_dvs <= VEL_BITS'(r_ta);
                r_cnt <= CNT_BITS'(SPEED_BITS - 1);
            end
            ST_DIVA: begin
                if (unit_last) begin
                    // Hold the rate and load the deceleration rate division
                    r_acc <= n_rate;
                    r_x   <= {diff_mag, {(X_BITS-SPEED_BITS){1'b0}}};
                    r_rem <= '0;
                    r_q   <= '0;
                    r_dvs <= VEL_BITS'(r_td);
                    r_cnt <= CNT_BITS'(SPEED_BITS - 1);
                end else begin
                    r_x   <= n_x;
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt - CNT_BITS'(1);
                end
            end
            ST_DIVD: begin
                r_x   <= n_x;
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (unit_last) begin
                    r_dec <= n_rate;
                end
            end
            ST_MUL: begin
                r_prod <= n_prod;
                case (r_mstep)
                    MS_VMIN_TA: r_ra <= R_BITS'(r_prod);
                    MS_DEC_TD:  r_ra <= r_ra + {r_prod[R_BITS-2:0], 1'b0};
                    MS_VMIN_TD: r_rd <= R_BITS'(r_prod);
                    MS_VMIN_SQ: r_rd <= r_rd + {r_prod[R_BITS-2:0], 1'b0};
                    MS_VMAX_SQ: begin
                        r_vv     <= r_prod[RSAT_BITS-1:0];
                        r_ceil_a <= ra_p1[R_BITS-1:1];
                        r_ceil_d <= rd_p1[R_BITS-1:1];
                    end
                    MS_BOUNDS: begin
                        r_vx    <= r_prod[RSAT_BITS-1:0];
                        r_short <= ({1'b0, r_total} <= ceil_sum);
                        r_min   <= MIN_BITS'(ceil_sum) + MIN_BITS'(1);
                        r_brk   <= {1'b0, r_total} - {1'b0, r_ceil_d};
                        // Take a counter outside the move as step zero
                        r_step  <= (CMP_BITS'(r_step_cnt) >= CMP_BITS'(r_total)) ? '0
                                 : MOVE_BITS'(r_step_cnt);
                    end
                    MS_PHASE: begin
                        if ({1'b0, r_step} < {1'b0, r_ceil_a}) begin
                            r_phase <= PH_ACCEL;
                        end else if ({1'b0, r_step} < r_brk) begin
                            r_phase <= PH_CRUISE;
                        end else begin
                            r_phase <= PH_BRAKE;
                        end
                        r_k <= k_full[MA_BITS-1:0];
                    end
                    MS_VEL_MUL: begin
                        r_vq <= {r_vmax, {VEL_FRAC_BITS{1'b0}}};
                    end
                    MS_RADICAND: begin
                        if (!rad_pos) begin
                            r_vq <= '0;
                        end else if (rad_big) begin
                            r_vq <= '1;
                        end
                        // Load the square root of the scaled radicand
                        r_x   <= {rad[RSAT_BITS-1:0], {(2*VEL_FRAC_BITS){1'b0}}};
                        r_rem <= '0;
                        r_q   <= '0;
                        r_cnt <= CNT_BITS'(VEL_BITS - 1);
                    end
                    default: ;
                endcase
            end
            ST_SQRT: begin
                r_x   <= n_x;
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (unit_last) begin
                    r_vq <= n_q[VEL_BITS-1:0];
                end
            end
            ST_PSTART: begin
                // Saturate the period for slow steps, else load the period division
                r_per <= '1;
                r_x   <= {PER_NUM_LOW, {(X_BITS-PER_BITS){1'b0}}};
                r_rem <= REM_BITS'(PER_SAT);
                r_q   <= '0;
                r_dvs <= r_vq;
                r_cnt <= CNT_BITS'(PER_BITS - 1);
            end
            ST_PDIV: begin
                r_x   <= n_x;
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (unit_last) begin
                    r_per <= n_q[PER_BITS-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (r_short) begin
                        r_o_step  <= '0;
                        r_o_vel   <= '0;
                        r_o_per   <= '0;
                        r_o_phase <= PH_ACCEL;
                        r_o_last  <= 1'b0;
                        r_o_short <= 1'b1;
                        r_o_min   <= r_min;
                    end else begin
                        r_o_step  <= r_step;
                        r_o_vel   <= r_vq;
                        r_o_per   <= r_per;
                        r_o_phase <= r_phase;
                        r_o_last  <= step_last;
                        r_o_short <= 1'b0;
                        r_o_min   <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
